// ----- design/arf_pkg.sv -----
// Shared types, constants and helpers for the ARGB alpha rectangle fill block.
// No dependencies.
package arf_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = $clog2(MAX_DIM) + 1;
	localparam int COORD_W   = 12;
	localparam int RECT_W    = 14;
	localparam int PIX_W     = 32;
	localparam int ADDR_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SURFACE_WIDTH  = 3'd0,
		REG_SURFACE_HEIGHT = 3'd1,
		REG_RECT_LEFT      = 3'd2,
		REG_RECT_TOP       = 3'd3,
		REG_RECT_WIDTH     = 3'd4,
		REG_RECT_HEIGHT    = 3'd5,
		REG_FILL_COLOR     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	// exact v/255 for v <= 255*255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'd1 + 17'(v[15:8]);
		return t[15:8];
	endfunction

endpackage

// ----- design/arf_blend.sv -----
// Source-over blend datapath, pipeline stages 2 and 3.
// Depends on arf_pkg.
module arf_blend (
	input  logic                    clk,
	input  arf_pkg::stage_en_t      en,
	input  logic [31:0]             dst_s1,
	input  logic [31:0]             color,
	output logic [31:0]             blend_s3
);
	import arf_pkg::*;

	logic [7:0]  a;
	logic [7:0]  inv;
	logic [15:0] sum_s2 [3];
	logic [15:0] aprod_s2;
	logic [7:0]  da_s2;
	logic [8:0]  na;

	assign a   = color[31:24];
	assign inv = 8'd255 - a;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= 16'(color[8*i +: 8]) * 16'(a) + 16'(dst_s1[8*i +: 8]) * 16'(inv);
			end
			aprod_s2 <= 16'(8'd255 - dst_s1[31:24]) * 16'(a);
			da_s2    <= dst_s1[31:24];
		end
	end

	assign na = {1'b0, da_s2} + {1'b0, div255(aprod_s2)};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 3; i++) begin
				blend_s3[8*i +: 8] <= div255(sum_s2[i]);
			end
			blend_s3[31:24] <= na[7:0];
		end
	end

endmodule

// ----- design/argb_alpha_rect_fill.sv -----
// Top level of the ARGB8888 alpha rectangle fill: config registers, clip test,
// address generation and the three-stage stream pipeline.
// Depends on arf_pkg and arf_blend.
// Each accepted input beat moves through stages 1, 2 and 3 to the matching output beat.
// Throughput: one beat per cycle unless m_tready is low; each stage stalls on its own.
// The row*width multiplier and the channel multipliers sit in stage 2, div255 in stage 3.
// Reset: all stages empty, registers back to width 640, height 480, others zero.
module argb_alpha_rect_fill (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [55:0]                     s_tdata,   // pixel_col, pixel_row, pixel_in
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [55:0]                     m_tdata,   // pixel_out, word_address
	output logic                            m_tuser,   // write_enable
	input  logic                            cfg_we,
	input  logic [arf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [arf_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import arf_pkg::*;

	logic [DIM_W-1:0]  sw_q, sh_q;
	logic [RECT_W-1:0] left_q, top_q, rw_q, rh_q;
	logic [PIX_W-1:0]  color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q    <= DIM_W'(640);
			sh_q    <= DIM_W'(480);
			left_q  <= '0;
			top_q   <= '0;
			rw_q    <= '0;
			rh_q    <= '0;
			color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SURFACE_WIDTH:  sw_q    <= cfg_data[DIM_W-1:0];
				REG_SURFACE_HEIGHT: sh_q    <= cfg_data[DIM_W-1:0];
				REG_RECT_LEFT:      left_q  <= cfg_data[RECT_W-1:0];
				REG_RECT_TOP:       top_q   <= cfg_data[RECT_W-1:0];
				REG_RECT_WIDTH:     rw_q    <= cfg_data[RECT_W-1:0];
				REG_RECT_HEIGHT:    rh_q    <= cfg_data[RECT_W-1:0];
				REG_FILL_COLOR:     color_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] sw_sat, sh_sat;
	assign sw_sat = (sw_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sw_q;
	assign sh_sat = (sh_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sh_q;

	logic [COORD_W-1:0] in_col, in_row;
	logic [PIX_W-1:0]   in_pix;
	assign in_col = s_tdata[11:0];
	assign in_row = s_tdata[23:12];
	assign in_pix = s_tdata[55:24];

	logic signed [RECT_W:0] col_x, row_x, left_x, top_x, rw_x, rh_x, cend_x, rend_x;
	logic col_ok, row_ok, we_in;

	assign col_x  = signed'({3'b000, in_col});
	assign row_x  = signed'({3'b000, in_row});
	assign left_x = signed'({left_q[RECT_W-1], left_q});
	assign top_x  = signed'({top_q[RECT_W-1], top_q});
	assign rw_x   = signed'({rw_q[RECT_W-1], rw_q});
	assign rh_x   = signed'({rh_q[RECT_W-1], rh_q});
	assign cend_x = left_x + rw_x;
	assign rend_x = top_x + rh_x;

	assign col_ok = (rw_x > 0) && ({1'b0, in_col} < sw_sat) && (col_x >= left_x) && (col_x < cend_x);
	assign row_ok = (rh_x > 0) && ({1'b0, in_row} < sh_sat) && (row_x >= top_x) && (row_x < rend_x);
	assign we_in  = (color_q[31:24] != 8'd0) && col_ok && row_ok;

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	stage_en_t en;

	assign adv3     = !v_s3 || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;
	assign en       = '{s2: adv2 && v_s1, s3: adv3 && v_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	logic [COORD_W-1:0] col_s1, row_s1;
	logic [PIX_W-1:0]   pix_s1, pix_s2, pix_s3;
	logic               we_s1, we_s2, we_s3;
	logic [ADDR_W-1:0]  addr_s2, addr_s3;
	logic [COORD_W+DIM_W-1:0] addr_full;

	assign addr_full = (COORD_W+DIM_W)'(row_s1) * (COORD_W+DIM_W)'(sw_sat)
		+ (COORD_W+DIM_W)'(col_s1);

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			col_s1 <= in_col;
			row_s1 <= in_row;
			pix_s1 <= in_pix;
			we_s1  <= we_in;
		end
		if (en.s2) begin
			addr_s2 <= addr_full[ADDR_W-1:0];
			pix_s2  <= pix_s1;
			we_s2   <= we_s1;
		end
		if (en.s3) begin
			addr_s3 <= addr_s2;
			pix_s3  <= pix_s2;
			we_s3   <= we_s2;
		end
	end

	logic [PIX_W-1:0] blend_s3;

	arf_blend u_blend (
		.clk      (clk),
		.en       (en),
		.dst_s1   (pix_s1),
		.color    (color_q),
		.blend_s3 (blend_s3)
	);

	assign m_tvalid = v_s3;
	assign m_tuser  = we_s3;
	assign m_tdata  = {addr_s3, we_s3 ? blend_s3 : pix_s3};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !m_tready) |=> (v_s3 && $stable(addr_s3) && $stable(we_s3)))
		else $error("output stage changed while stalled");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv2) |=> (v_s2 && $stable(pix_s2) && $stable(addr_s2)))
		else $error("stage 2 changed while stalled");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !m_tready) |-> !s_tready)
		else $error("full pipeline accepted a beat under backpressure");

endmodule
